// ----- design/i2crts_pkg.sv -----
// shared types and constants of the i2c register transfer sequencer
// no dependencies

package i2crts_pkg;

    localparam int BUFFER_BYTES = 10;
    localparam int LEN_CAP      = (BUFFER_BYTES - 1) < 9 ? (BUFFER_BYTES - 1) : 9;
    localparam int ADDR_W       = 6;
    localparam int DATA_W       = 64;

    localparam logic [3:0] LEN_CAP_W    = 4'(LEN_CAP);
    localparam logic [3:0] LEN_RESET    = 4'd2;

    // register indexes, at byte address 8*index
    localparam logic [2:0] REG_SLAVE_ADDRESS = 3'd0;
    localparam logic [2:0] REG_READ_MODE     = 3'd1;
    localparam logic [2:0] REG_WORD_ADDRESS  = 3'd2;
    localparam logic [2:0] REG_LENGTH_MARK   = 3'd3;
    localparam logic [2:0] REG_WRITE_BYTES   = 3'd4;

    // controller status codes
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_RESTART    = 8'h10;
    localparam logic [7:0] ST_SLA_W_ACK  = 8'h18;
    localparam logic [7:0] ST_SLA_W_NACK = 8'h20;
    localparam logic [7:0] ST_DATA_W_ACK = 8'h28;
    localparam logic [7:0] ST_SLA_R_ACK  = 8'h40;
    localparam logic [7:0] ST_DATA_R_NACK = 8'h58;
    localparam logic       RW_READ_BIT   = 1'b1;

    typedef enum logic [1:0] {
        ACT_BEGIN   = 2'd0,
        ACT_STATUS  = 2'd1,
        ACT_TIMEOUT = 2'd2
    } t_action;

    typedef struct packed {
        logic [6:0]  slave_address;
        logic        read_mode;
        logic [7:0]  word_address;
        logic [3:0]  length_mark;
        logic [63:0] write_bytes;
    } t_cfg;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] status_code;
        logic [7:0] received_byte;
    } t_in_word;

    typedef struct packed {
        logic       issue_command;
        logic       cmd_start;
        logic       cmd_stop;
        logic       cmd_clear_flag;
        logic       cmd_ack;
        logic       write_valid;
        logic [7:0] write_byte;
        logic       read_valid;
        logic [2:0] read_index;
        logic [7:0] read_byte;
        logic       done_res;
        logic       data_good;
    } t_out_word;

endpackage

// ----- design/i2crts_cfg.sv -----
// configuration register file with apb-style access
// depends on i2crts_pkg

module i2crts_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [i2crts_pkg::ADDR_W-1:0]    paddr,
    input  logic [i2crts_pkg::DATA_W-1:0]    pwdata,
    output logic [i2crts_pkg::DATA_W-1:0]    prdata,
    output logic                             pready,
    output i2crts_pkg::t_cfg                 o_cfg
);
    import i2crts_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;
    logic [3:0] len_in;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[ADDR_W-1:3];
    assign len_in  = pwdata[3:0];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave_address <= '0;
            r_cfg.read_mode     <= 1'b0;
            r_cfg.word_address  <= '0;
            r_cfg.length_mark   <= LEN_RESET;
            r_cfg.write_bytes   <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SLAVE_ADDRESS: r_cfg.slave_address <= pwdata[6:0];
                REG_READ_MODE:     r_cfg.read_mode     <= pwdata[0];
                REG_WORD_ADDRESS:  r_cfg.word_address  <= pwdata[7:0];
                REG_LENGTH_MARK:   r_cfg.length_mark   <= (len_in > LEN_CAP_W) ? LEN_CAP_W
                                                                               : len_in;
                REG_WRITE_BYTES:   r_cfg.write_bytes   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SLAVE_ADDRESS: prdata = DATA_W'(r_cfg.slave_address);
            REG_READ_MODE:     prdata = DATA_W'(r_cfg.read_mode);
            REG_WORD_ADDRESS:  prdata = DATA_W'(r_cfg.word_address);
            REG_LENGTH_MARK:   prdata = DATA_W'(r_cfg.length_mark);
            REG_WRITE_BYTES:   prdata = r_cfg.write_bytes;
            default:           prdata = '0;
        endcase
    end

endmodule

// ----- design/i2crts_seq.sv -----
// transaction state and per-word decision logic
// depends on i2crts_pkg

module i2crts_seq (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  i2crts_pkg::t_cfg       i_cfg,
    input  i2crts_pkg::t_in_word   i_word,
    output i2crts_pkg::t_out_word  o_word
);
    import i2crts_pkg::*;

    logic       r_started, n_started;
    logic       r_ended,   n_ended;
    logic [3:0] r_count,   n_count;
    logic       r_valid,   n_valid;

    t_out_word  res;
    logic [2:0] slot;
    logic [7:0] sla_w;
    logic       below;

    assign slot   = 3'(r_count - 4'd1);
    assign sla_w  = {i_cfg.slave_address, 1'b0};
    assign below  = r_count < i_cfg.length_mark;

    always_comb begin
        n_started = r_started;
        n_ended   = r_ended;
        n_count   = r_count;
        n_valid   = r_valid;
        res       = '0;
        case (t_action'(i_word.action))
            ACT_BEGIN: begin
                n_started = 1'b0;
                n_ended   = 1'b0;
                if (i_cfg.read_mode) n_valid = 1'b1;
                res.issue_command = 1'b1;
                res.cmd_start     = 1'b1;
            end
            ACT_STATUS: begin
                if (r_ended) begin
                    res.issue_command  = 1'b1;
                    res.cmd_stop       = 1'b1;
                    res.cmd_clear_flag = 1'b1;
                end else if (i_word.status_code == ST_START) begin
                    res.issue_command  = 1'b1;
                    res.cmd_clear_flag = 1'b1;
                    if (!r_started) begin
                        n_count         = '0;
                        res.write_valid = 1'b1;
                        res.write_byte  = sla_w;
                        n_started       = 1'b1;
                    end else begin
                        n_ended      = 1'b1;
                        res.cmd_stop = 1'b1;
                        if (i_cfg.read_mode) n_valid = 1'b0;
                    end
                end else if (i_word.status_code == ST_SLA_W_ACK) begin
                    res.write_valid    = 1'b1;
                    res.write_byte     = i_cfg.word_address;
                    n_count            = 4'(r_count + 4'd1);
                    res.issue_command  = 1'b1;
                    res.cmd_clear_flag = 1'b1;
                end else if (i_word.status_code == ST_SLA_W_NACK) begin
                    res.issue_command  = 1'b1;
                    res.cmd_start      = 1'b1;
                    res.cmd_stop       = 1'b1;
                    res.cmd_clear_flag = 1'b1;
                end else if (i_word.status_code == ST_DATA_W_ACK && !i_cfg.read_mode) begin
                    res.issue_command  = 1'b1;
                    res.cmd_clear_flag = 1'b1;
                    if (below) begin
                        res.write_valid = 1'b1;
                        res.write_byte  = (r_count == 4'd0) ? 8'(i_cfg.length_mark)
                                                            : i_cfg.write_bytes[slot*8 +: 8];
                        n_count         = 4'(r_count + 4'd1);
                    end else begin
                        res.cmd_stop = 1'b1;
                        n_ended      = 1'b1;
                    end
                end else if (i_word.status_code == ST_DATA_W_ACK) begin
                    res.issue_command  = 1'b1;
                    res.cmd_start      = 1'b1;
                    res.cmd_clear_flag = 1'b1;
                end else if (i_word.status_code == ST_RESTART && i_cfg.read_mode) begin
                    res.write_valid    = 1'b1;
                    res.write_byte     = {i_cfg.slave_address, RW_READ_BIT};
                    res.issue_command  = 1'b1;
                    res.cmd_clear_flag = 1'b1;
                end else if (i_word.status_code == ST_SLA_R_ACK && i_cfg.read_mode) begin
                    res.issue_command  = 1'b1;
                    res.cmd_clear_flag = 1'b1;
                end else if (i_word.status_code == ST_DATA_R_NACK && i_cfg.read_mode) begin
                    res.issue_command  = 1'b1;
                    res.cmd_clear_flag = 1'b1;
                    if (below) begin
                        if (r_count != 4'd0) begin
                            res.read_valid = 1'b1;
                            res.read_index = slot;
                            res.read_byte  = i_word.received_byte;
                        end
                        n_count = 4'(r_count + 4'd1);
                    end else begin
                        res.cmd_stop = 1'b1;
                        n_ended      = 1'b1;
                    end
                end else begin
                    n_ended = 1'b1;
                    if (i_cfg.read_mode) n_valid = 1'b0;
                end
            end
            ACT_TIMEOUT: begin
                n_ended = 1'b1;
            end
            default: ;
        endcase
        res.done_res  = n_ended;
        res.data_good = n_valid;
    end

    assign o_word = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_ended   <= 1'b0;
            r_count   <= '0;
            r_valid   <= 1'b0;
        end else if (i_fire) begin
            r_started <= n_started;
            r_ended   <= n_ended;
            r_count   <= n_count;
            r_valid   <= n_valid;
        end
    end

endmodule

// ----- design/i2c_master_register_transfer_sequencer.sv -----
// top level of the i2c master register transfer sequencer
// depends on i2crts_pkg, i2crts_cfg and i2crts_seq
//
// channel   direction  handshake               payload
// in        input      i_in_valid / o_in_stall  i_in_data  (t_in_word)
// out       output     o_out_valid / i_out_stall o_out_data (t_out_word)
// cfg       input      psel/penable/pwrite      paddr, pwdata, prdata
//
// one word per cycle sustained while the output is not stalled; a word lands in the
// input register, is decided against the flags and byte counter, and its result
// sits in the output register.
// synchronous active-low reset clears flags, counter and both valid bits.
// a stall on the output holds the result register and then the input register.

module i2c_master_register_transfer_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  i2crts_pkg::t_in_word             i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output i2crts_pkg::t_out_word            o_out_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [i2crts_pkg::ADDR_W-1:0]    paddr,
    input  logic [i2crts_pkg::DATA_W-1:0]    pwdata,
    output logic [i2crts_pkg::DATA_W-1:0]    prdata,
    output logic                             pready
);
    import i2crts_pkg::*;

    t_cfg      cfg;
    t_in_word  r_in;
    logic      r_in_valid;
    t_out_word r_out;
    logic      r_out_valid;
    t_out_word seq_res;
    logic      move;
    logic      take;

    assign move        = r_in_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall  = r_in_valid & r_out_valid & i_out_stall;
    assign take        = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    i2crts_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    i2crts_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (move),
        .i_cfg   (cfg),
        .i_word  (r_in),
        .o_word  (seq_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (~i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) r_in <= i_in_data;
        if (move) r_out <= seq_res;
    end

endmodule

// ----- test/i2c_master_register_transfer_sequencer_test.sv -----
// self-checking test of the i2c master register transfer sequencer
// depends on i2crts_pkg and the design top level; predicts every result word
// from begin, status, timeout and unused-action words under changing register settings

module i2c_master_register_transfer_sequencer_test;
    import i2crts_pkg::*;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 600000;
    localparam int         SEGMENTS    = 8;
    localparam int         SEG_WORDS   = 205;

    class sequencer_scoreboard;
        logic [6:0]  slave_addr = '0;
        logic        rd_mode    = 1'b0;
        logic [7:0]  sub_addr   = '0;
        logic [3:0]  len_mark   = LEN_RESET;
        logic [63:0] payload    = '0;
        logic        started    = 1'b0;
        logic        ended      = 1'b0;
        logic        good       = 1'b0;
        logic [3:0]  count      = '0;
        t_out_word   res;
        t_out_word   expected_steps[$];
        int          n_errors   = 0;
        int          n_checked  = 0;

        function void set_register(logic [2:0] idx, logic [63:0] value);
            case (idx)
                REG_SLAVE_ADDRESS: slave_addr = value[6:0];
                REG_READ_MODE:     rd_mode = value[0];
                REG_WORD_ADDRESS:  sub_addr = value[7:0];
                REG_LENGTH_MARK:   len_mark = (value[3:0] > LEN_CAP_W) ? LEN_CAP_W : value[3:0];
                REG_WRITE_BYTES:   payload = value;
                default: ;
            endcase
        endfunction

        function void issue(logic sta, logic sto, logic clr);
            res.issue_command  = 1'b1;
            res.cmd_start      = sta;
            res.cmd_stop       = sto;
            res.cmd_clear_flag = clr;
            res.cmd_ack        = 1'b0;
        endfunction

        function void note_status_word(t_in_word w);
            logic [7:0] st;
            logic [2:0] slot;
            st  = w.status_code;
            res = '0;
            case (w.action)
                ACT_BEGIN: begin
                    started = 1'b0;
                    ended   = 1'b0;
                    if (rd_mode) good = 1'b1;
                    issue(1'b1, 1'b0, 1'b0);
                end
                ACT_TIMEOUT: ended = 1'b1;
                ACT_STATUS: begin
                    if (ended) begin
                        issue(1'b0, 1'b1, 1'b1);
                    end else if (st == ST_START) begin
                        if (!started) begin
                            count           = '0;
                            res.write_valid = 1'b1;
                            res.write_byte  = {slave_addr, 1'b0};
                            issue(1'b0, 1'b0, 1'b1);
                            started = 1'b1;
                        end else begin
                            ended = 1'b1;
                            issue(1'b0, 1'b1, 1'b1);
                            if (rd_mode) good = 1'b0;
                        end
                    end else if (st == ST_SLA_W_ACK) begin
                        res.write_valid = 1'b1;
                        res.write_byte  = sub_addr;
                        count           = count + 4'd1;
                        issue(1'b0, 1'b0, 1'b1);
                    end else if (st == ST_SLA_W_NACK) begin
                        issue(1'b1, 1'b1, 1'b1);
                    end else if (st == ST_DATA_W_ACK && !rd_mode) begin
                        if (count < len_mark) begin
                            slot            = 3'(count - 4'd1);
                            res.write_valid = 1'b1;
                            res.write_byte  = (count == 0) ? {4'd0, len_mark}
                                                           : payload[8*slot +: 8];
                            count           = count + 4'd1;
                            issue(1'b0, 1'b0, 1'b1);
                        end else begin
                            issue(1'b0, 1'b1, 1'b1);
                            ended = 1'b1;
                        end
                    end else if (st == ST_DATA_W_ACK) begin
                        issue(1'b1, 1'b0, 1'b1);
                    end else if (st == ST_RESTART && rd_mode) begin
                        res.write_valid = 1'b1;
                        res.write_byte  = {slave_addr, RW_READ_BIT};
                        issue(1'b0, 1'b0, 1'b1);
                    end else if (st == ST_SLA_R_ACK && rd_mode) begin
                        issue(1'b0, 1'b0, 1'b1);
                    end else if (st == ST_DATA_R_NACK && rd_mode) begin
                        if (count < len_mark) begin
                            if (count != 0) begin
                                res.read_valid = 1'b1;
                                res.read_index = 3'(count - 4'd1);
                                res.read_byte  = w.received_byte;
                            end
                            count = count + 4'd1;
                            issue(1'b0, 1'b0, 1'b1);
                        end else begin
                            issue(1'b0, 1'b1, 1'b1);
                            ended = 1'b1;
                        end
                    end else begin
                        ended = 1'b1;
                        if (rd_mode) good = 1'b0;
                    end
                end
                default: ;
            endcase
            res.done_res  = ended;
            res.data_good = good;
            expected_steps.push_back(res);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                n_errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_step_result(t_out_word got);
            t_out_word want;
            if (expected_steps.size() == 0) begin
                n_errors++;
                $display("%0t: result word with nothing expected, actual %h", $time, got);
                return;
            end
            want = expected_steps.pop_front();
            n_checked++;
            compare_field("issue_command", want.issue_command, got.issue_command);
            compare_field("cmd_start", want.cmd_start, got.cmd_start);
            compare_field("cmd_stop", want.cmd_stop, got.cmd_stop);
            compare_field("cmd_clear_flag", want.cmd_clear_flag, got.cmd_clear_flag);
            compare_field("cmd_ack", want.cmd_ack, got.cmd_ack);
            compare_field("write_valid", want.write_valid, got.write_valid);
            compare_field("write_byte", want.write_byte, got.write_byte);
            compare_field("read_valid", want.read_valid, got.read_valid);
            compare_field("read_index", want.read_index, got.read_index);
            compare_field("read_byte", want.read_byte, got.read_byte);
            compare_field("done_res", want.done_res, got.done_res);
            compare_field("data_good", want.data_good, got.data_good);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_word    in_data;
    logic        out_valid;
    logic        out_stall;
    t_out_word   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic        pready;

    sequencer_scoreboard sb;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int cycle_count   = 0;
    int words_sent    = 0;
    int transactions  = 0;
    int settings      = 0;

    i2c_master_register_transfer_sequencer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) sb.check_step_result(out_data);
    end

    function automatic t_in_word make_word(logic [1:0] act, logic [7:0] st);
        t_in_word w;
        w.action        = act;
        w.status_code   = st;
        w.received_byte = 8'($urandom_range(255));
        return w;
    endfunction

    function automatic t_in_word noise_word();
        logic [7:0] codes[7];
        logic [7:0] st;
        codes = '{ST_START, ST_RESTART, ST_SLA_W_ACK, ST_SLA_W_NACK,
                  ST_DATA_W_ACK, ST_SLA_R_ACK, ST_DATA_R_NACK};
        st = ($urandom_range(1) == 0) ? codes[$urandom_range(6)] : 8'($urandom_range(255));
        return make_word(2'($urandom_range(3)), st);
    endfunction

    task automatic send_word(t_in_word w);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge i_clk); while (in_stall);
        sb.note_status_word(w);
        words_sent++;
    endtask

    task automatic wait_all_results();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (sb.expected_steps.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [63:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_register(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(logic [6:0] sla, logic mode, logic [7:0] wa,
                             logic [3:0] len, logic [63:0] bytes);
        write_register(REG_SLAVE_ADDRESS, {57'd0, sla});
        write_register(REG_READ_MODE, {63'd0, mode});
        write_register(REG_WORD_ADDRESS, {56'd0, wa});
        write_register(REG_LENGTH_MARK, {60'd0, len});
        write_register(REG_WRITE_BYTES, bytes);
        settings++;
    endtask

    task automatic run_transaction();
        t_in_word plan[$];
        int n;
        n = int'(sb.len_mark) + $urandom_range(2);
        plan.push_back(make_word(ACT_BEGIN, 8'($urandom_range(255))));
        plan.push_back(make_word(ACT_STATUS, ST_START));
        plan.push_back(make_word(ACT_STATUS, ST_SLA_W_ACK));
        if (sb.rd_mode) begin
            plan.push_back(make_word(ACT_STATUS, ST_DATA_W_ACK));
            plan.push_back(make_word(ACT_STATUS, ST_RESTART));
            plan.push_back(make_word(ACT_STATUS, ST_SLA_R_ACK));
            repeat (n) plan.push_back(make_word(ACT_STATUS, ST_DATA_R_NACK));
        end else begin
            repeat (n) plan.push_back(make_word(ACT_STATUS, ST_DATA_W_ACK));
        end
        foreach (plan[k]) begin
            if ($urandom_range(99) < 4) send_word(noise_word());
            if ($urandom_range(99) >= 3) send_word(plan[k]);
        end
        transactions++;
    endtask

    initial begin
        int idle_table[4];
        int stall_table[4];
        int target;
        logic [3:0] len;
        idle_table  = '{0, 86, 0, 23};
        stall_table = '{0, 0, 86, 23};
        sb       = new();
        i_rst_n  = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        out_stall = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // write transfer with a saturated length mark, then corner statuses
        configure(7'h7F, 1'b0, 8'hA5, 4'd15, 64'h0123_4567_89AB_CDEF);
        send_word(make_word(ACT_BEGIN, 8'h00));
        send_word(make_word(ACT_STATUS, ST_START));
        send_word(make_word(ACT_STATUS, ST_SLA_W_ACK));
        repeat (10) send_word(make_word(ACT_STATUS, ST_DATA_W_ACK));
        send_word(make_word(ACT_STATUS, ST_DATA_W_ACK));
        send_word(make_word(ACT_BEGIN, 8'hFF));
        send_word(make_word(ACT_STATUS, ST_START));
        send_word(make_word(ACT_STATUS, ST_START));
        send_word(make_word(ACT_BEGIN, 8'h00));
        send_word(make_word(ACT_STATUS, ST_SLA_W_NACK));
        send_word(make_word(ACT_UNUSED, 8'hFF));
        send_word(make_word(ACT_STATUS, 8'hFF));
        send_word(make_word(ACT_TIMEOUT, 8'h00));
        wait_all_results();

        // read transfer with repeated start and two stored bytes
        configure(7'h55, 1'b1, 8'h00, 4'd3, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(make_word(ACT_BEGIN, 8'h00));
        send_word(make_word(ACT_STATUS, ST_START));
        send_word(make_word(ACT_STATUS, ST_SLA_W_ACK));
        send_word(make_word(ACT_STATUS, ST_DATA_W_ACK));
        send_word(make_word(ACT_STATUS, ST_RESTART));
        send_word(make_word(ACT_STATUS, ST_SLA_R_ACK));
        repeat (3) send_word(make_word(ACT_STATUS, ST_DATA_R_NACK));

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            wait_all_results();
            send_idle_pct = idle_table[seg / 2];
            stall_pct     = stall_table[seg / 2];
            len = (seg == 0) ? 4'd0 : (seg == 6) ? 4'd9 : (seg == 7) ? 4'd15
                                    : 4'($urandom_range(15, 1));
            case (seg)
                0: configure(7'h00, 1'b0, 8'h00, len, 64'd0);
                7: configure(7'h7F, 1'b1, 8'hFF, len, 64'hFFFF_FFFF_FFFF_FFFF);
                default: configure(7'($urandom_range(127)), seg[0], 8'($urandom_range(255)),
                                   len, {$urandom, $urandom});
            endcase
            target = words_sent + SEG_WORDS;
            while (words_sent < target) begin
                if ($urandom_range(99) < 12) begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end else begin
                    send_idle_pct = idle_table[seg / 2];
                    stall_pct     = stall_table[seg / 2];
                end
                if ($urandom_range(99) < 10) send_word(noise_word());
                else run_transaction();
                if ($urandom_range(99) < 2) wait_all_results();
            end
        end

        wait_all_results();
        repeat (10) @(posedge i_clk);
        $display("sent %0d words in %0d transfers over %0d register settings",
                 words_sent, transactions, settings);
        $display("checked %0d result words, %0d mismatches", sb.n_checked, sb.n_errors);
        if (sb.n_errors == 0 && sb.expected_steps.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
